### rtl/sjb_pkg.sv
// sjb_pkg: shared types, constants and helper functions for the text cell buffer
// no dependencies
`timescale 1ns / 1ps

package sjb_pkg;

    // default store geometry
    localparam int DEF_MAX_COLS = 128;
    localparam int DEF_MAX_ROWS = 64;

    // width of a full cell index sum: 16-bit product plus 9-bit column
    localparam int SUM_W = 17;

    // cell values and character codes
    localparam logic [15:0] BLANK_CELL = 16'h0720;
    localparam logic [7:0]  TTY_ATTR   = 8'h07;
    localparam logic [7:0]  CH_CR      = 8'h0D;
    localparam logic [7:0]  CH_LF      = 8'h0A;
    localparam logic [7:0]  CH_BS      = 8'h08;
    localparam logic [7:0]  DEF_COLS   = 8'd80;

    // register reset values
    localparam logic [7:0] RST_COLUMNS  = 8'd80;
    localparam logic [5:0] RST_LAST_ROW = 6'd24;

    // configuration register indexes
    localparam logic CFG_COLUMNS  = 1'b0;
    localparam logic CFG_LAST_ROW = 1'b1;

    // item kinds
    localparam logic [1:0] KIND_STR  = 2'd0;
    localparam logic [1:0] KIND_TTY  = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;
    localparam logic [1:0] KIND_CUR  = 2'd3;

    // one input beat as held inside the block
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] byte_value;
        logic [7:0] attr;
        logic       start_req;
        logic [7:0] col_field;
        logic [7:0] row_field;
        logic       last;
        logic       cursor_follow;
    } t_in_item;

    // result of the cell index unit
    typedef struct packed {
        logic             ok;
        logic [SUM_W-1:0] idx;
    } t_addr_res;

    // shift-jis lead byte ranges
    function automatic logic is_lead(input logic [7:0] c);
        logic r;
        r = ((c >= 8'h81) && (c <= 8'h9F)) || ((c >= 8'hE0) && (c <= 8'hFC));
        return r;
    endfunction

    // row advance, saturating at 255
    function automatic logic [7:0] next_row(input logic [7:0] r);
        logic [7:0] n;
        n = (r == 8'hFF) ? r : r + 8'd1;
        return n;
    endfunction

    // column count in use, zero meaning the default
    function automatic logic [7:0] eff_cols(input logic [7:0] c);
        logic [7:0] n;
        n = (c == 8'd0) ? DEF_COLS : c;
        return n;
    endfunction

endpackage

### rtl/sjb_if.sv
// sjb_in_if and sjb_out_if: valid/ready channels for items and results
// depends on nothing
`timescale 1ns / 1ps

interface sjb_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] byte_value;
    logic [7:0] attr;
    logic       start_req;
    logic [7:0] col_field;
    logic [7:0] row_field;
    logic       last;
    logic       cursor_follow;

    modport source (
        output valid, kind, byte_value, attr, start_req, col_field, row_field,
               last, cursor_follow,
        input  ready
    );
    modport sink (
        input  valid, kind, byte_value, attr, start_req, col_field, row_field,
               last, cursor_follow,
        output ready
    );
endinterface

interface sjb_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] cell_res;
    logic [7:0]  end_col;
    logic [7:0]  cursor_col;
    logic [7:0]  cursor_row;

    modport source (
        output valid, cell_res, end_col, cursor_col, cursor_row,
        input  ready
    );
    modport sink (
        input  valid, cell_res, end_col, cursor_col, cursor_row,
        output ready
    );
endinterface

### rtl/sjb_cell_mem.sv
// sjb_cell_mem: cell store with one write and one registered read port,
// plus the clearing sweep run after reset and on request; uses sjb_pkg
`timescale 1ns / 1ps

module sjb_cell_mem #(
    parameter int DEPTH = sjb_pkg::DEF_MAX_COLS * sjb_pkg::DEF_MAX_ROWS,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic             i_we,
    input  logic [IDX_W-1:0] i_waddr,
    input  logic [15:0]      i_wdata,
    input  logic             i_re,
    input  logic [IDX_W-1:0] i_raddr,
    output logic [15:0]      o_rdata,
    output logic             o_busy
);
    import sjb_pkg::*;

    logic [15:0]      r_mem [DEPTH];
    logic [15:0]      r_rdata;
    logic [IDX_W-1:0] r_cnt;
    logic             r_busy;

    // sweep control: restart on reset or clear request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (r_cnt == IDX_W'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // write port, sweep has priority
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_cnt] <= BLANK_CELL;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

### rtl/sjb_addr_gen.sv
// sjb_addr_gen: cell index unit, registered row times columns product,
// then column add and range checks; uses sjb_pkg
`timescale 1ns / 1ps

module sjb_addr_gen #(
    parameter int DEPTH = sjb_pkg::DEF_MAX_COLS * sjb_pkg::DEF_MAX_ROWS
) (
    input  logic                i_clk,
    input  logic                i_load,
    input  logic [8:0]          i_col,
    input  logic [7:0]          i_row,
    input  logic [7:0]          i_cols,
    input  logic [6:0]          i_rows,
    input  logic                i_second,
    output sjb_pkg::t_addr_res  o_addr
);
    import sjb_pkg::*;

    logic [15:0] r_prod;
    logic [8:0]  r_col;
    logic        r_row_ok;
    logic [8:0]  col;
    logic [SUM_W-1:0] sum;

    // first stage: product and row check
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod   <= i_row * i_cols;
            r_col    <= i_col;
            r_row_ok <= i_row < {1'b0, i_rows};
        end
    end

    // second stage: index and column / depth checks
    always_comb begin
        col         = r_col + {8'd0, i_second};
        sum         = {1'b0, r_prod} + SUM_W'(col);
        o_addr.idx  = sum;
        o_addr.ok   = r_row_ok && (col < {1'b0, i_cols}) && (sum < SUM_W'(DEPTH));
    end

endmodule

### rtl/sjis_text_cell_buffer.sv
// sjis_text_cell_buffer: top level, item sequencer, position and cursor state,
// configuration and result register; uses sjb_pkg, sjb_if, sjb_addr_gen, sjb_cell_mem
`timescale 1ns / 1ps

//  channel   dir  handshake      beat
//  i_in      in   valid/ready    kind, byte_value, attr, start_req, col/row, last, follow
//  o_out     out  valid/ready    cell_res, end_col, cursor_col, cursor_row
//  i_cfg_*   in   write enable   index 0 columns, index 1 last_row_index
//
//  an item is accepted only while idle; each passes the plan, access and done steps,
//  with a second access step for a double-byte pair, as the single write port of the
//  cell store writes one cell a cycle; its result is registered on leaving done.
//  reset and any change of geometry start a clearing pass over all MAX_COLS*MAX_ROWS
//  cells (8192 by default) during which no item is accepted.
//  a result waits in the output register; the next item is accepted meanwhile
//  and is held at its last step until the waiting result is taken.

module sjis_text_cell_buffer #(
    parameter int MAX_COLS = sjb_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = sjb_pkg::DEF_MAX_ROWS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sjb_in_if.sink     i_in,
    sjb_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    import sjb_pkg::*;

    localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;
    localparam int IDX_W       = $clog2(STORE_DEPTH);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PLAN = 3'd1;
    localparam logic [2:0] S_ACC0 = 3'd2;
    localparam logic [2:0] S_ACC1 = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0] r_state, n_state;
    t_in_item   r_item;

    // position state
    logic [7:0] r_pend_lead, n_pend_lead;
    logic [7:0] r_pend_attr, n_pend_attr;
    logic       r_pend_valid, n_pend_valid;
    logic [8:0] r_write_col, n_write_col;
    logic [7:0] r_write_row, n_write_row;
    logic [7:0] r_string_row, n_string_row;
    logic [7:0] r_cur_col, n_cur_col;
    logic [7:0] r_cur_row, n_cur_row;

    // configuration
    logic [7:0] r_columns, n_columns;
    logic [5:0] r_last_row, n_last_row;
    logic [7:0] cols;
    logic [6:0] rows;
    logic       geo_change;

    // access plan
    logic [8:0]  p_col;
    logic [7:0]  p_row;
    logic        p_wr0, p_wr1, p_rd;
    logic [15:0] p_d0, p_d1;
    logic        r_wr0, r_wr1, r_rd, r_rd_ok;
    logic [15:0] r_d0, r_d1;

    // result register
    logic        r_out_valid;
    logic [15:0] r_cell_res;
    logic [7:0]  r_end_col, r_cursor_col, r_cursor_row;
    logic        out_load;

    // memory and index unit
    t_addr_res   addr;
    logic        mem_we, mem_re, mem_busy;
    logic [15:0] mem_wdata, mem_rdata;
    logic        in_acc;

    // scratch for planning
    logic [8:0] s_wc;
    logic [7:0] s_wr, s_srow;
    logic       s_pv, s_wrote;
    logic [8:0] s_cc;

    assign cols = eff_cols(r_columns);
    assign rows = {1'b0, r_last_row} + 7'd2;

    // configuration writes, clear on a geometry change
    always_comb begin
        n_columns  = r_columns;
        n_last_row = r_last_row;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLUMNS:  n_columns  = i_cfg_data;
                CFG_LAST_ROW: n_last_row = i_cfg_data[5:0];
                default:      n_columns  = r_columns;
            endcase
        end
        geo_change = (eff_cols(n_columns) != cols) || (n_last_row != r_last_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns  <= RST_COLUMNS;
            r_last_row <= RST_LAST_ROW;
        end else begin
            r_columns  <= n_columns;
            r_last_row <= n_last_row;
        end
    end

    // handshake
    assign i_in.ready = (r_state == S_IDLE) && !mem_busy;
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    // item planning: state updates and cell accesses
    always_comb begin
        n_pend_lead  = r_pend_lead;
        n_pend_attr  = r_pend_attr;
        n_pend_valid = r_pend_valid;
        n_write_col  = r_write_col;
        n_write_row  = r_write_row;
        n_string_row = r_string_row;
        n_cur_col    = r_cur_col;
        n_cur_row    = r_cur_row;
        p_col = '0;
        p_row = '0;
        p_wr0 = 1'b0;
        p_wr1 = 1'b0;
        p_rd  = 1'b0;
        p_d0  = '0;
        p_d1  = '0;
        s_wc    = r_item.start_req ? {1'b0, r_item.col_field} : r_write_col;
        s_wr    = r_item.start_req ? r_item.row_field : r_write_row;
        s_srow  = r_item.start_req ? r_item.row_field : r_string_row;
        s_pv    = r_item.start_req ? 1'b0 : r_pend_valid;
        s_wrote = 1'b1;
        s_cc    = {1'b0, r_cur_col} + 9'd1;
        case (r_item.kind)
            KIND_STR: begin
                n_write_col  = s_wc;
                n_write_row  = s_wr;
                n_string_row = s_srow;
                n_pend_valid = s_pv;
                p_col = s_wc;
                p_row = s_wr;
                if (s_pv) begin
                    // held lead with this trail byte: two cells
                    p_wr0 = 1'b1;
                    p_wr1 = 1'b1;
                    p_d0  = {r_pend_attr, r_pend_lead};
                    p_d1  = {r_pend_attr, r_item.byte_value};
                    n_write_col  = s_wc + 9'd2;
                    n_pend_valid = 1'b0;
                end else if (is_lead(r_item.byte_value) && !r_item.last) begin
                    // lead byte held for its trail
                    n_pend_lead  = r_item.byte_value;
                    n_pend_attr  = r_item.attr;
                    n_pend_valid = 1'b1;
                    s_wrote      = 1'b0;
                end else begin
                    p_wr0 = 1'b1;
                    p_d0  = {r_item.attr, r_item.byte_value};
                    n_write_col = s_wc + 9'd1;
                end
                if (s_wrote && (n_write_col >= {1'b0, cols})) begin
                    n_write_col = '0;
                    n_write_row = next_row(s_wr);
                end
                if (r_item.last && r_item.cursor_follow) begin
                    n_cur_col = n_write_col[7:0];
                    n_cur_row = s_srow;
                end
            end
            KIND_TTY: begin
                p_col = {1'b0, r_cur_col};
                p_row = r_cur_row;
                case (r_item.byte_value)
                    CH_CR: n_cur_col = '0;
                    CH_LF: n_cur_row = next_row(r_cur_row);
                    CH_BS: begin
                        if (r_cur_col != 8'd0) begin
                            n_cur_col = r_cur_col - 8'd1;
                        end
                    end
                    default: begin
                        p_wr0 = 1'b1;
                        p_d0  = {TTY_ATTR, r_item.byte_value};
                        if (s_cc >= {1'b0, cols}) begin
                            n_cur_col = '0;
                            n_cur_row = next_row(r_cur_row);
                        end else begin
                            n_cur_col = s_cc[7:0];
                        end
                    end
                endcase
            end
            KIND_READ: begin
                p_col = {1'b0, r_item.col_field};
                p_row = r_item.row_field;
                p_rd  = 1'b1;
            end
            default: begin
                n_cur_col = r_item.col_field;
                n_cur_row = r_item.row_field;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (in_acc) n_state = S_PLAN;
            S_PLAN: n_state = S_ACC0;
            S_ACC0: n_state = r_wr1 ? S_ACC1 : S_DONE;
            S_ACC1: n_state = S_DONE;
            S_DONE: if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pend_lead  <= '0;
            r_pend_attr  <= '0;
            r_pend_valid <= 1'b0;
            r_write_col  <= '0;
            r_write_row  <= '0;
            r_string_row <= '0;
            r_cur_col    <= '0;
            r_cur_row    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_PLAN) begin
                r_pend_lead  <= n_pend_lead;
                r_pend_attr  <= n_pend_attr;
                r_pend_valid <= n_pend_valid;
                r_write_col  <= n_write_col;
                r_write_row  <= n_write_row;
                r_string_row <= n_string_row;
                r_cur_col    <= n_cur_col;
                r_cur_row    <= n_cur_row;
            end
        end
    end

    // item capture and access plan registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item.kind          <= i_in.kind;
            r_item.byte_value    <= i_in.byte_value;
            r_item.attr          <= i_in.attr;
            r_item.start_req     <= i_in.start_req;
            r_item.col_field     <= i_in.col_field;
            r_item.row_field     <= i_in.row_field;
            r_item.last          <= i_in.last;
            r_item.cursor_follow <= i_in.cursor_follow;
        end
        if (r_state == S_PLAN) begin
            r_wr0 <= p_wr0;
            r_wr1 <= p_wr1;
            r_rd  <= p_rd;
            r_d0  <= p_d0;
            r_d1  <= p_d1;
        end
        if (r_state == S_ACC0) begin
            r_rd_ok <= addr.ok;
        end
    end

    // cell index unit
    sjb_addr_gen #(
        .DEPTH (STORE_DEPTH)
    ) u_addr (
        .i_clk    (i_clk),
        .i_load   (r_state == S_PLAN),
        .i_col    (p_col),
        .i_row    (p_row),
        .i_cols   (cols),
        .i_rows   (rows),
        .i_second (r_state == S_ACC1),
        .o_addr   (addr)
    );

    // cell store accesses
    assign mem_we    = addr.ok && (((r_state == S_ACC0) && r_wr0) || (r_state == S_ACC1));
    assign mem_re    = (r_state == S_ACC0) && r_rd;
    assign mem_wdata = (r_state == S_ACC1) ? r_d1 : r_d0;

    sjb_cell_mem #(
        .DEPTH (STORE_DEPTH),
        .IDX_W (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (i_cfg_we && geo_change),
        .i_we    (mem_we),
        .i_waddr (addr.idx[IDX_W-1:0]),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (addr.idx[IDX_W-1:0]),
        .o_rdata (mem_rdata),
        .o_busy  (mem_busy)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_cell_res   <= r_rd ? (r_rd_ok ? mem_rdata : BLANK_CELL) : 16'd0;
            r_end_col    <= r_write_col[7:0];
            r_cursor_col <= r_cur_col;
            r_cursor_row <= r_cur_row;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.cell_res   = r_cell_res;
    assign o_out.end_col    = r_end_col;
    assign o_out.cursor_col = r_cursor_col;
    assign o_out.cursor_row = r_cursor_row;

endmodule

### sim/tb_top.sv
// tb_top: self-checking bench for sjis_text_cell_buffer, directed items then random traffic
// keeps its own cell store and cursor state to predict every result beat
// depends on rtl/sjb_pkg.sv, rtl/sjb_if.sv and the block's rtl
`timescale 1ns / 1ps

module tb_top;
    import sjb_pkg::*;

    localparam int STORE_DEPTH  = DEF_MAX_COLS * DEF_MAX_ROWS;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 600;
    localparam int DUE_DEPTH    = 16;

    // one result beat as the bench predicts it
    typedef struct packed {
        logic [15:0] cell_res;
        logic [7:0]  end_col;
        logic [7:0]  cursor_col;
        logic [7:0]  cursor_row;
    } t_text_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [7:0] i_cfg_data;

    sjb_in_if  in_ch ();
    sjb_out_if out_ch ();

    sjis_text_cell_buffer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow of the block state
    logic [15:0] shadow_cells [STORE_DEPTH];
    logic [7:0]  lead_byte;
    logic [7:0]  lead_attr;
    logic        lead_held;
    logic [8:0]  str_col;
    logic [7:0]  str_row;
    logic [7:0]  str_home_row;
    logic [7:0]  cur_col;
    logic [7:0]  cur_row;
    logic [7:0]  reg_columns;
    logic [5:0]  reg_last_row;

    // predicted beats in acceptance order
    t_text_result due_fifo [DUE_DEPTH];
    logic [3:0]   due_wr = '0;
    logic [3:0]   due_rd = '0;
    t_text_result chk_want;
    t_text_result chk_got;

    int mismatches  = 0;
    int items_sent  = 0;
    int cycle_count = 0;
    int rx_hold     = 0;
    bit idle_on     = 1'b1;
    int gen_col     = 0;
    int gen_row     = 0;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- prediction

    function automatic int cols_used();
        return (reg_columns == 8'd0) ? int'(DEF_COLS) : int'(reg_columns);
    endfunction

    function automatic int rows_used();
        return int'(reg_last_row) + 2;
    endfunction

    // store slot of a position; false outside the text area
    function automatic bit cell_slot(input int col, input int row, output int slot);
        slot = row * cols_used() + col;
        return (col < cols_used()) && (row < rows_used()) && (slot < STORE_DEPTH);
    endfunction

    function automatic void put_cell(input int col, input int row,
                                     input logic [7:0] a, input logic [7:0] ch);
        int slot;
        if (cell_slot(col, row, slot)) shadow_cells[slot] = {a, ch};
    endfunction

    function automatic logic [15:0] get_cell(input int col, input int row);
        int slot;
        if (cell_slot(col, row, slot)) return shadow_cells[slot];
        return BLANK_CELL;
    endfunction

    function automatic bit sjis_lead_byte(input logic [7:0] b);
        return ((b >= 8'h81) && (b <= 8'h9F)) || ((b >= 8'hE0) && (b <= 8'hFC));
    endfunction

    function automatic logic [7:0] row_after(input logic [7:0] r);
        return (r == 8'hFF) ? r : r + 8'd1;
    endfunction

    function automatic void blank_store();
        foreach (shadow_cells[i]) shadow_cells[i] = BLANK_CELL;
    endfunction

    // register write; a change of geometry wipes the store
    function automatic void shadow_config(input logic idx, input logic [7:0] val);
        int old_c;
        int old_r;
        old_c = cols_used();
        old_r = rows_used();
        if (idx == CFG_COLUMNS) reg_columns = val;
        else reg_last_row = val[5:0];
        if ((cols_used() != old_c) || (rows_used() != old_r)) blank_store();
    endfunction

    // advance the shadow by one item and return the beat it must produce
    function automatic t_text_result step_text_buffer(input t_in_item it);
        t_text_result r;
        int cols;
        bit placed;
        cols = cols_used();
        r.cell_res = '0;
        case (it.kind)
            KIND_STR: begin
                placed = 1'b1;
                if (it.start_req) begin
                    str_col      = {1'b0, it.col_field};
                    str_row      = it.row_field;
                    str_home_row = it.row_field;
                    lead_held    = 1'b0;
                end
                if (lead_held) begin
                    // double-byte pair fills two cells
                    put_cell(int'(str_col), int'(str_row), lead_attr, lead_byte);
                    put_cell(int'(str_col) + 1, int'(str_row), lead_attr, it.byte_value);
                    str_col   = str_col + 9'd2;
                    lead_held = 1'b0;
                end else if (sjis_lead_byte(it.byte_value) && !it.last) begin
                    lead_byte = it.byte_value;
                    lead_attr = it.attr;
                    lead_held = 1'b1;
                    placed    = 1'b0;
                end else begin
                    put_cell(int'(str_col), int'(str_row), it.attr, it.byte_value);
                    str_col = str_col + 9'd1;
                end
                if (placed && (str_col >= cols)) begin
                    str_col = '0;
                    str_row = row_after(str_row);
                end
                if (it.last && it.cursor_follow) begin
                    cur_col = str_col[7:0];
                    cur_row = str_home_row;
                end
            end
            KIND_TTY: begin
                if (it.byte_value == CH_CR) begin
                    cur_col = 8'd0;
                end else if (it.byte_value == CH_LF) begin
                    cur_row = row_after(cur_row);
                end else if (it.byte_value == CH_BS) begin
                    if (cur_col != 8'd0) cur_col = cur_col - 8'd1;
                end else begin
                    put_cell(int'(cur_col), int'(cur_row), TTY_ATTR, it.byte_value);
                    if (int'(cur_col) + 1 >= cols) begin
                        cur_col = 8'd0;
                        cur_row = row_after(cur_row);
                    end else begin
                        cur_col = cur_col + 8'd1;
                    end
                end
            end
            KIND_READ: begin
                r.cell_res = get_cell(int'(it.col_field), int'(it.row_field));
            end
            KIND_CUR: begin
                cur_col = it.col_field;
                cur_row = it.row_field;
            end
        endcase
        r.end_col    = str_col[7:0];
        r.cursor_col = cur_col;
        r.cursor_row = cur_row;
        return r;
    endfunction

    // ---------------------------------------------------------------- driving

    function automatic t_in_item mk_item(input logic [1:0] kind, input logic [7:0] bv,
                                         input logic [7:0] at, input logic st,
                                         input logic [7:0] cf, input logic [7:0] rf,
                                         input logic lst, input logic fol);
        t_in_item it;
        it.kind          = kind;
        it.byte_value    = bv;
        it.attr          = at;
        it.start_req     = st;
        it.col_field     = cf;
        it.row_field     = rf;
        it.last          = lst;
        it.cursor_follow = fol;
        return it;
    endfunction

    // send one item beat; valid stays high when no gap follows
    task automatic send_item(input t_in_item it);
        int gap;
        gap = idle_on ? int'($urandom_range(0, 3)) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.kind          <= it.kind;
        in_ch.byte_value    <= it.byte_value;
        in_ch.attr          <= it.attr;
        in_ch.start_req     <= it.start_req;
        in_ch.col_field     <= it.col_field;
        in_ch.row_field     <= it.row_field;
        in_ch.last          <= it.last;
        in_ch.cursor_follow <= it.cursor_follow;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        due_fifo[due_wr] = step_text_buffer(it);
        due_wr = due_wr + 4'd1;
        items_sent++;
    endtask

    // stop sending and let every awaited beat come back
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (due_wr != due_rd) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    // both registers, back to back; only called while idle
    task automatic set_geometry(input logic [7:0] cols, input logic [5:0] last_row);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_COLUMNS;
        i_cfg_data <= cols;
        @(posedge i_clk);
        shadow_config(CFG_COLUMNS, cols);
        i_cfg_idx  <= CFG_LAST_ROW;
        i_cfg_data <= {2'b00, last_row};
        @(posedge i_clk);
        shadow_config(CFG_LAST_ROW, {2'b00, last_row});
        i_cfg_we   <= 1'b0;
    endtask

    // result side: after each taken beat, ready stays low until a random countdown, run only while valid, ends
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready) rx_hold = idle_on ? int'($urandom_range(0, 3)) : 0;
        else if (out_ch.valid && (rx_hold > 0)) rx_hold--;
        out_ch.ready <= (rx_hold == 0);
    end

    // compare each result beat with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            chk_got = {out_ch.cell_res, out_ch.end_col, out_ch.cursor_col, out_ch.cursor_row};
            if (due_wr == due_rd) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: cell %h end_col %0d cursor %0d,%0d",
                             chk_got.cell_res, chk_got.end_col,
                             chk_got.cursor_col, chk_got.cursor_row);
            end else begin
                chk_want = due_fifo[due_rd];
                due_rd   = due_rd + 4'd1;
                if (chk_got !== chk_want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: cell %h/%h end_col %0d/%0d cursor %0d,%0d/%0d,%0d",
                                 chk_want.cell_res, chk_got.cell_res,
                                 chk_want.end_col, chk_got.end_col,
                                 chk_want.cursor_col, chk_want.cursor_row,
                                 chk_got.cursor_col, chk_got.cursor_row);
                end
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ---------------------------------------------------------------- directed tests

    // blank store after reset, in range and far out of range
    task automatic test_blank_reads();
        send_item(mk_item(KIND_READ, 8'h00, 8'h00, 1'b0, 8'd79, 8'd24, 1'b0, 1'b0));
        send_item(mk_item(KIND_READ, 8'hFF, 8'hFF, 1'b1, 8'd255, 8'd255, 1'b1, 1'b1));
    endtask

    // pairs, lone lead at the end, pair cut at the last column, discarded lead
    task automatic test_string_bytes();
        send_item(mk_item(KIND_STR, 8'h81, 8'h2E, 1'b1, 8'd0, 8'd1, 1'b0, 1'b0));
        send_item(mk_item(KIND_STR, 8'h40, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(mk_item(KIND_STR, 8'hFC, 8'hFF, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(mk_item(KIND_STR, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(mk_item(KIND_STR, 8'hFF, 8'h80, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(mk_item(KIND_STR, 8'hE0, 8'h01, 1'b0, 8'd0, 8'd0, 1'b1, 1'b1));
        send_item(mk_item(KIND_STR, 8'h9F, 8'h4A, 1'b1, 8'd79, 8'd2, 1'b0, 1'b0));
        send_item(mk_item(KIND_STR, 8'h41, 8'h00, 1'b0, 8'd0, 8'd0, 1'b1, 1'b1));
        send_item(mk_item(KIND_STR, 8'h88, 8'h33, 1'b1, 8'd10, 8'd3, 1'b0, 1'b0));
        send_item(mk_item(KIND_STR, 8'h80, 8'h55, 1'b1, 8'd255, 8'd255, 1'b1, 1'b1));
        send_item(mk_item(KIND_READ, 8'h00, 8'h00, 1'b0, 8'd0, 8'd1, 1'b0, 1'b0));
        send_item(mk_item(KIND_READ, 8'h00, 8'h00, 1'b0, 8'd1, 8'd1, 1'b0, 1'b0));
        send_item(mk_item(KIND_READ, 8'h00, 8'h00, 1'b0, 8'd79, 8'd2, 1'b0, 1'b0));
    endtask

    // wrap at the row end, backspace at column 0, CR, LF and row saturation
    task automatic test_teletype();
        send_item(mk_item(KIND_CUR, 8'h00, 8'h00, 1'b0, 8'd79, 8'd5, 1'b0, 1'b0));
        send_item(mk_item(KIND_TTY, 8'h78, 8'hFF, 1'b1, 8'd0, 8'd0, 1'b1, 1'b1));
        send_item(mk_item(KIND_TTY, CH_BS, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(mk_item(KIND_TTY, CH_CR, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(mk_item(KIND_TTY, CH_LF, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(mk_item(KIND_CUR, 8'h00, 8'h00, 1'b0, 8'd255, 8'd255, 1'b0, 1'b0));
        send_item(mk_item(KIND_TTY, 8'h41, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0));
        send_item(mk_item(KIND_TTY, CH_LF, 8'h00, 1'b0, 8'd0, 8'd0, 1'b0, 1'b0));
    endtask

    // same geometry keeps the store, a new one wipes it
    task automatic test_geometry();
        settle();
        set_geometry(8'd80, 6'd24);
        send_item(mk_item(KIND_READ, 8'h00, 8'h00, 1'b0, 8'd1, 8'd1, 1'b0, 1'b0));
        settle();
        set_geometry(8'd1, 6'd0);
        send_item(mk_item(KIND_READ, 8'h00, 8'h00, 1'b0, 8'd0, 8'd1, 1'b0, 1'b0));
    endtask

    // ---------------------------------------------------------------- random traffic

    // well-formed string with random content, now and then without its start
    task automatic rand_string();
        int len;
        bit broken;
        bit pair_open;
        bit lst;
        logic [7:0] bv;
        logic [7:0] cf;
        logic [7:0] rf;
        len    = int'($urandom_range(1, 10));
        broken = ($urandom_range(0, 7) == 0);
        if ($urandom_range(0, 9) == 0) begin
            cf = 8'($urandom);
            rf = 8'($urandom);
        end else begin
            cf = 8'($urandom_range(0, cols_used() - 1));
            rf = 8'($urandom_range(0, rows_used() - 1));
        end
        gen_col   = int'(cf);
        gen_row   = int'(rf);
        pair_open = 1'b0;
        for (int i = 0; i < len; i++) begin
            lst = (i == len - 1);
            if (pair_open) bv = 8'($urandom);
            else if ($urandom_range(0, 2) == 0)
                bv = $urandom_range(0, 1) ? 8'($urandom_range(8'h81, 8'h9F))
                                          : 8'($urandom_range(8'hE0, 8'hFC));
            else if ($urandom_range(0, 1) == 0) bv = 8'($urandom_range(8'h20, 8'h7E));
            else bv = 8'($urandom);
            if ((i == 0) && !broken)
                send_item(mk_item(KIND_STR, bv, 8'($urandom), 1'b1, cf, rf, lst,
                                  1'($urandom)));
            else
                send_item(mk_item(KIND_STR, bv, 8'($urandom), 1'b0, 8'($urandom),
                                  8'($urandom), lst, 1'($urandom)));
            pair_open = !pair_open && sjis_lead_byte(bv) && !lst;
        end
    endtask

    // cursor placement, half the time, then a burst of teletype characters
    task automatic rand_teletype();
        int n;
        logic [7:0] bv;
        if ($urandom_range(0, 1) == 0) begin
            if ($urandom_range(0, 9) == 0) begin
                gen_col = int'($urandom_range(0, 255));
                gen_row = int'($urandom_range(0, 255));
            end else begin
                gen_col = int'($urandom_range(0, cols_used() - 1));
                gen_row = int'($urandom_range(0, rows_used() - 1));
            end
            send_item(mk_item(KIND_CUR, 8'($urandom), 8'($urandom), 1'($urandom),
                              8'(gen_col), 8'(gen_row), 1'($urandom), 1'($urandom)));
        end
        n = int'($urandom_range(1, 8));
        repeat (n) begin
            case ($urandom_range(0, 5))
                0:       bv = CH_CR;
                1:       bv = CH_LF;
                2:       bv = CH_BS;
                default: bv = 8'($urandom);
            endcase
            send_item(mk_item(KIND_TTY, bv, 8'($urandom), 1'($urandom), 8'($urandom),
                              8'($urandom), 1'($urandom), 1'($urandom)));
        end
    endtask

    // reads mostly around the last string start or cursor placement chosen
    task automatic rand_reads();
        int n;
        logic [7:0] cf;
        logic [7:0] rf;
        n = int'($urandom_range(1, 4));
        repeat (n) begin
            case ($urandom_range(0, 9))
                0: begin
                    cf = 8'($urandom);
                    rf = 8'($urandom);
                end
                1, 2: begin
                    cf = 8'($urandom_range(0, cols_used() - 1));
                    rf = 8'($urandom_range(0, rows_used() - 1));
                end
                default: begin
                    cf = 8'(gen_col + int'($urandom_range(0, 11)));
                    rf = 8'(gen_row + int'($urandom_range(0, 1)));
                end
            endcase
            send_item(mk_item(KIND_READ, 8'($urandom), 8'($urandom), 1'($urandom), cf, rf,
                              1'($urandom), 1'($urandom)));
        end
    endtask

    // phases of mixed traffic, each under its own geometry and idling mode
    task automatic test_random_traffic();
        int goal;
        int phase_end;
        int phase;
        logic [7:0] cols;
        logic [5:0] last_row;
        goal  = items_sent + RANDOM_ITEMS;
        phase = 0;
        while (items_sent < goal) begin
            settle();
            if (phase == 0) begin
                cols     = 8'd128;
                last_row = 6'd62;
            end else if (phase == 1) begin
                cols     = 8'd1;
                last_row = 6'd0;
            end else begin
                if ($urandom_range(0, 2) == 0) cols = $urandom_range(0, 1) ? 8'd1 : 8'd128;
                else cols = 8'($urandom_range(1, 128));
                if ($urandom_range(0, 2) == 0) last_row = $urandom_range(0, 1) ? 6'd0 : 6'd62;
                else last_row = 6'($urandom_range(0, 62));
            end
            set_geometry(cols, last_row);
            idle_on   = ($urandom_range(0, 3) != 0);
            phase_end = items_sent + int'($urandom_range(70, 110));
            while ((items_sent < phase_end) && (items_sent < goal)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: rand_string();
                    4, 5:       rand_teletype();
                    6, 7, 8:    rand_reads();
                    default:
                        send_item(mk_item(2'($urandom), 8'($urandom), 8'($urandom),
                                          1'($urandom), 8'($urandom), 8'($urandom),
                                          1'($urandom), 1'($urandom)));
                endcase
            end
            phase++;
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial begin
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= CFG_COLUMNS;
        i_cfg_data          <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.kind          <= KIND_STR;
        in_ch.byte_value    <= '0;
        in_ch.attr          <= '0;
        in_ch.start_req     <= 1'b0;
        in_ch.col_field     <= '0;
        in_ch.row_field     <= '0;
        in_ch.last          <= 1'b0;
        in_ch.cursor_follow <= 1'b0;

        // shadow state after reset
        blank_store();
        lead_byte    = '0;
        lead_attr    = '0;
        lead_held    = 1'b0;
        str_col      = '0;
        str_row      = '0;
        str_home_row = '0;
        cur_col      = '0;
        cur_row      = '0;
        reg_columns  = RST_COLUMNS;
        reg_last_row = RST_LAST_ROW;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_blank_reads();
        test_string_bytes();
        test_teletype();
        test_geometry();
        test_random_traffic();
        settle();

        if ((mismatches == 0) && (due_wr == due_rd)) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
